/* hdl/lih_pkg.sv */
// Shared types and constants for the identity history table.
// Used by lih_cell and lru_identity_history_table_core.
`timescale 1ns / 1ps
package lih_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam int KEY_W       = 64;
    localparam int NODE_W      = 16;
    localparam int STAMP_W     = 32;

    localparam logic OP_NOTE  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // scan token handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic [NODE_W-1:0]  node;
        logic [STAMP_W-1:0] min_stamp;
    } tok_t;

    // write-back command broadcast to all cells
    typedef struct packed {
        logic               en;
        logic               load_key;
        logic [NODE_W-1:0]  node;
        logic [STAMP_W-1:0] stamp;
    } wr_t;

endpackage

/* hdl/lru_identity_history_table_core.sv */
// Top level of the identity history table: control, use tick and the cell chain.
// Depends on lih_pkg and lih_cell.
`timescale 1ns / 1ps
// Usage:
//   A word is taken when start is high and busy is low: op, ident_high,
//   ident_low and node_id. op note refreshes or inserts the identity (LRU
//   replacement when full); op query only looks it up.
//   One result word per input word: done is high for exactly one cycle with
//   found and node_id_out valid in that cycle. The receiver cannot stall.
//   Busy drops in the same cycle that done is high, so a new word can be
//   taken in that cycle; no new word is taken while a scan is in progress.
//   The scan token walks the chain of ENTRIES
//   cells one cell per cycle, checking for a match and tracking the oldest
//   stamp; the write-back into the chosen cell overlaps the next word.
//   Reset clears the fill count, the use tick and the control state; entry
//   contents are never read at or above the fill count, so they need no clearing.
module lru_identity_history_table_core #(
    parameter int ENTRIES = lih_pkg::ENTRIES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         op,
    input  logic [lih_pkg::KEY_W-1:0]    ident_high,
    input  logic [lih_pkg::KEY_W-1:0]    ident_low,
    input  logic [lih_pkg::NODE_W-1:0]   node_id,
    output logic                         done,
    output logic                         found,
    output logic [lih_pkg::NODE_W-1:0]   node_id_out
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]                  fill_reg, fill_next;
    logic [lih_pkg::STAMP_W-1:0]    tick_reg, tick_next;
    logic                           op_reg;
    logic [lih_pkg::KEY_W-1:0]      key_hi_reg;
    logic [lih_pkg::KEY_W-1:0]      key_lo_reg;
    logic [lih_pkg::NODE_W-1:0]     nid_reg;

    lih_pkg::tok_t                  tok_in_reg, tok_in_next;
    lih_pkg::wr_t                   wr_reg, wr_next;
    logic [IW-1:0]                  wr_idx_reg, wr_idx_next;

    logic                           done_reg, done_next;
    logic                           found_reg, found_next;
    logic [lih_pkg::NODE_W-1:0]     nout_reg, nout_next;

    lih_pkg::tok_t                  tok_w     [ENTRIES+1];
    logic [IW-1:0]                  hit_idx_w [ENTRIES+1];
    logic [IW-1:0]                  min_idx_w [ENTRIES+1];

    logic                           accept;
    lih_pkg::tok_t                  tail;

    assign accept = start && (state_reg == ST_IDLE);
    assign tail   = tok_w[ENTRIES];

    assign tok_w[0]     = tok_in_reg;
    assign hit_idx_w[0] = '0;
    assign min_idx_w[0] = '0;

    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_cell
        lih_cell #(
            .INDEX   (k),
            .IW      (IW),
            .CW      (CW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .fill        (fill_reg),
            .key_hi      (key_hi_reg),
            .key_lo      (key_lo_reg),
            .tok_in      (tok_w[k]),
            .hit_idx_in  (hit_idx_w[k]),
            .min_idx_in  (min_idx_w[k]),
            .tok_out     (tok_w[k+1]),
            .hit_idx_out (hit_idx_w[k+1]),
            .min_idx_out (min_idx_w[k+1]),
            .wr          (wr_reg),
            .wr_idx      (wr_idx_reg)
        );
    end

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        tick_next   = tick_reg;
        tok_in_next = '0;
        tok_in_next.min_stamp = '1;
        wr_next     = '0;
        wr_idx_next = wr_idx_reg;
        done_next   = 1'b0;
        found_next  = found_reg;
        nout_next   = nout_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    tok_in_next.valid = 1'b1;
                    if (op == lih_pkg::OP_NOTE)
                    begin
                        tick_next = tick_reg + 1'b1;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tail.valid)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    found_next = tail.hit;
                    if (op_reg == lih_pkg::OP_QUERY)
                    begin
                        nout_next = tail.hit ? tail.node : '0;
                    end
                    else
                    begin
                        nout_next     = '0;
                        wr_next.en    = 1'b1;
                        wr_next.node  = nid_reg;
                        wr_next.stamp = tick_reg;
                        if (tail.hit)
                        begin
                            wr_idx_next = hit_idx_w[ENTRIES];
                        end
                        else if (fill_reg < FULL)
                        begin
                            wr_next.load_key = 1'b1;
                            wr_idx_next      = IW'(fill_reg);
                            fill_next        = fill_reg + 1'b1;
                        end
                        else
                        begin
                            wr_next.load_key = 1'b1;
                            wr_idx_next      = min_idx_w[ENTRIES];
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            tick_reg   <= '0;
            tok_in_reg <= '0;
            wr_reg     <= '0;
            wr_idx_reg <= '0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
            nout_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            tick_reg   <= tick_next;
            tok_in_reg <= tok_in_next;
            wr_reg     <= wr_next;
            wr_idx_reg <= wr_idx_next;
            done_reg   <= done_next;
            found_reg  <= found_next;
            nout_reg   <= nout_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= op;
            key_hi_reg <= ident_high;
            key_lo_reg <= ident_low;
            nid_reg    <= node_id;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign found       = found_reg;
    assign node_id_out = nout_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL)
        else $error("fill count beyond table size");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accepted word");

    a_tail_done: assert property (@(posedge clk) disable iff (!rst_n)
        (tail.valid && state_reg == ST_SCAN) |=> (done && !busy))
        else $error("scan end did not produce a result");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_write_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        wr_reg.en |-> done)
        else $error("write-back without matching result");

endmodule

/* hdl/lih_cell.sv */
// One table entry of the identity history chain: stores key, node id and stamp,
// updates the passing scan token. Depends on lih_pkg.
`timescale 1ns / 1ps
module lih_cell #(
    parameter int INDEX   = 0,
    parameter int IW      = 1,
    parameter int CW      = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [CW-1:0]               fill,
    input  logic [lih_pkg::KEY_W-1:0]   key_hi,
    input  logic [lih_pkg::KEY_W-1:0]   key_lo,
    input  lih_pkg::tok_t               tok_in,
    input  logic [IW-1:0]               hit_idx_in,
    input  logic [IW-1:0]               min_idx_in,
    output lih_pkg::tok_t               tok_out,
    output logic [IW-1:0]               hit_idx_out,
    output logic [IW-1:0]               min_idx_out,
    input  lih_pkg::wr_t                wr,
    input  logic [IW-1:0]               wr_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
    localparam logic [CW-1:0] MY_CNT = CW'(INDEX);

    logic [lih_pkg::KEY_W-1:0]   key_hi_reg;
    logic [lih_pkg::KEY_W-1:0]   key_lo_reg;
    logic [lih_pkg::NODE_W-1:0]  node_reg;
    logic [lih_pkg::STAMP_W-1:0] stamp_reg;

    lih_pkg::tok_t tok_reg, tok_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [IW-1:0] min_idx_reg, min_idx_next;
    logic          live;

    assign live = (MY_CNT < fill);

    always_comb
    begin
        tok_next     = tok_in;
        hit_idx_next = hit_idx_in;
        min_idx_next = min_idx_in;
        if (live && !tok_in.hit && key_hi_reg == key_hi && key_lo_reg == key_lo)
        begin
            tok_next.hit  = 1'b1;
            tok_next.node = node_reg;
            hit_idx_next  = MY_IDX;
        end
        if (live && stamp_reg < tok_in.min_stamp)
        begin
            tok_next.min_stamp = stamp_reg;
            min_idx_next       = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg     <= '0;
            hit_idx_reg <= '0;
            min_idx_reg <= '0;
        end
        else
        begin
            tok_reg     <= tok_next;
            hit_idx_reg <= hit_idx_next;
            min_idx_reg <= min_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr_idx == MY_IDX)
        begin
            node_reg  <= wr.node;
            stamp_reg <= wr.stamp;
            if (wr.load_key)
            begin
                key_hi_reg <= key_hi;
                key_lo_reg <= key_lo;
            end
        end
    end

    assign tok_out     = tok_reg;
    assign hit_idx_out = hit_idx_reg;
    assign min_idx_out = min_idx_reg;

endmodule
